@@ hdl/frc_pkg.sv @@
// ----------------------------------------------------------------------------
// frc_pkg
// Shared commands, class codes and binary64 field constants.
// ----------------------------------------------------------------------------
package frc_pkg;

  typedef enum logic [2:0] {
    CMD_CLASSIFY = 3'd0,
    CMD_TRUNC    = 3'd1,
    CMD_FLOOR    = 3'd2,
    CMD_CEIL     = 3'd3,
    CMD_RINT     = 3'd4,
    CMD_FREXP    = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    CLS_NAN       = 3'd0,
    CLS_INF       = 3'd1,
    CLS_ZERO      = 3'd2,
    CLS_SUBNORMAL = 3'd3,
    CLS_NORMAL    = 3'd4
  } cls_e;

  localparam logic [63:0] EXP_FIELD  = 64'h7ff0_0000_0000_0000;
  localparam logic [63:0] MIN_NORMAL = 64'h0010_0000_0000_0000;
  localparam logic [63:0] FRAC_FIELD = 64'h000f_ffff_ffff_ffff;
  localparam logic [63:0] HALF_BITS  = 64'h3fe0_0000_0000_0000;
  localparam logic [63:0] SIGN_BIT   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE_BITS   = 64'h3ff0_0000_0000_0000;
  localparam logic [10:0] EXP_BIAS   = 11'd1023;

  // stage 1 -> stage 2
  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] x;
    cls_e        cls;
    logic [63:0] mask;     // fraction bits below the binary point
    logic [63:0] unit;     // one ulp of integer part
    logic        big;      // e >= 52
    logic        sub_one;  // e < 0
    logic        tiny;     // e < -1
    logic [5:0]  lz;       // leading zeros of 52-bit fraction
  } s1_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] x;
    cls_e        cls;
    logic [63:0] chop;
    logic [63:0] dir;      // chop + unit
    logic        exact;
    logic        rup;      // round-half-even increment
    logic        big;
    logic        sub_one;
    logic        tiny;
    logic [5:0]  lz;
  } s2_t;

endpackage

@@ hdl/frc_lzc.sv @@
// ----------------------------------------------------------------------------
// frc_lzc
// Leading-zero count of a 52-bit fraction field.
// ----------------------------------------------------------------------------
module frc_lzc (
  input  logic [51:0] frac_i,
  output logic [5:0]  count_o
);
  always_comb begin
    count_o = 6'd52;
    for (int i = 0; i < 52; i++) begin
      if (frac_i[i]) count_o = 6'(51 - i);
    end
  end
endmodule

@@ hdl/fp64_round_classify_unit.sv @@
// ----------------------------------------------------------------------------
// fp64_round_classify_unit
// Binary64 classify, trunc, floor, ceil, rint and frexp.
// ----------------------------------------------------------------------------
// Path: an accepted beat is registered in stage 1, then stage 2, then the output register.
// Throughput: one beat per cycle, set by a three-stage pipeline with a global
// stall; a stalled output holds every stage.
// Reset clears the valid bits only; payload registers are not reset.
module fp64_round_classify_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [63:0] operand_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_out_o,
  output logic signed [11:0] exponent_out_o,
  output logic [2:0]  fp_class_o
);
  logic v1_q, v2_q, v3_q;
  logic adv;
  frc_pkg::s1_t s1_d, s1_q;
  frc_pkg::s2_t s2_d, s2_q;
  logic [63:0] val_d, val_q;
  logic [11:0] ex_d, ex_q;
  logic [2:0]  cls_q;
  logic [5:0]  lz;

  assign adv        = !(v3_q && out_stall_i);
  assign in_stall_o = !adv;

  frc_lzc u_lzc (.frac_i(operand_i[51:0]), .count_o(lz));

  // stage 1: decode
  always_comb begin
    logic [63:0] mag;
    logic [11:0] e;
    logic [6:0]  sh;
    mag = operand_i & ~frc_pkg::SIGN_BIT;
    e   = {1'b0, operand_i[62:52]} - {1'b0, frc_pkg::EXP_BIAS};
    s1_d.cmd = command_i;
    s1_d.x   = operand_i;
    if (mag > frc_pkg::EXP_FIELD)       s1_d.cls = frc_pkg::CLS_NAN;
    else if (mag == frc_pkg::EXP_FIELD) s1_d.cls = frc_pkg::CLS_INF;
    else if (mag == 64'd0)              s1_d.cls = frc_pkg::CLS_ZERO;
    else if (mag < frc_pkg::MIN_NORMAL) s1_d.cls = frc_pkg::CLS_SUBNORMAL;
    else                                s1_d.cls = frc_pkg::CLS_NORMAL;
    s1_d.sub_one = e[11];
    s1_d.tiny    = e[11] && (e != 12'hfff);
    s1_d.big     = !e[11] && (e >= 12'd52);
    sh = 7'd52 - e[6:0];
    s1_d.unit = (s1_d.sub_one || s1_d.big) ? 64'd0 : (64'd1 << sh[5:0]);
    s1_d.mask = s1_d.unit - 64'd1;
    s1_d.lz   = lz;
  end

  // stage 2: chop and rounding decision
  always_comb begin
    logic [63:0] rem, half;
    s2_d.cmd = s1_q.cmd;
    s2_d.x   = s1_q.x;
    s2_d.cls = s1_q.cls;
    s2_d.big = s1_q.big;
    s2_d.sub_one = s1_q.sub_one;
    s2_d.tiny    = s1_q.tiny;
    s2_d.lz      = s1_q.lz;
    if (s1_q.sub_one)  s2_d.chop = s1_q.x & frc_pkg::SIGN_BIT;
    else if (s1_q.big) s2_d.chop = s1_q.x;
    else               s2_d.chop = s1_q.x & ~s1_q.mask;
    s2_d.exact = (s2_d.chop == s1_q.x);
    s2_d.dir   = s2_d.chop + s1_q.unit;
    // e < 0 (rup is used only at e = -1): mantissa half-point is the implicit bit, q = 0
    if (s1_q.sub_one) begin
      rem  = 64'd0;
      half = 64'd0;
      s2_d.rup = (s1_q.x[51:0] != 52'd0);
    end else begin
      rem  = s1_q.x & s1_q.mask;
      half = s1_q.unit >> 1;
      s2_d.rup = (rem > half) || (rem == half && (s1_q.x & s1_q.unit) != 64'd0);
    end
  end

  // stage 3: select result
  always_comb begin
    logic spec, neg, away;
    logic [63:0] sgn;
    sgn  = s2_q.x & frc_pkg::SIGN_BIT;
    neg  = s2_q.x[63];
    spec = (s2_q.cls == frc_pkg::CLS_NAN) || (s2_q.cls == frc_pkg::CLS_INF)
           || (s2_q.cls == frc_pkg::CLS_ZERO);
    val_d = 64'd0;
    ex_d  = 12'd0;
    away  = 1'b0;
    case (s2_q.cmd)
      frc_pkg::CMD_TRUNC: val_d = s2_q.x[62:0] > frc_pkg::EXP_FIELD[62:0] ? s2_q.x : s2_q.chop;
      frc_pkg::CMD_FLOOR, frc_pkg::CMD_CEIL: begin
        away = (s2_q.cmd == frc_pkg::CMD_FLOOR) ? neg : !neg;
        if (s2_q.cls == frc_pkg::CLS_NAN || s2_q.exact || !away) val_d =
            (s2_q.cls == frc_pkg::CLS_NAN) ? s2_q.x : s2_q.chop;
        else if (s2_q.sub_one) val_d = sgn | frc_pkg::ONE_BITS;
        else val_d = s2_q.dir;
      end
      frc_pkg::CMD_RINT: begin
        if (spec || s2_q.big)   val_d = s2_q.x;
        else if (s2_q.tiny)     val_d = 64'd0;
        else if (s2_q.rup)      val_d = s2_q.sub_one ? (sgn | frc_pkg::ONE_BITS) : s2_q.dir;
        else if (s2_q.sub_one)  val_d = 64'd0;
        else                    val_d = s2_q.chop;
      end
      frc_pkg::CMD_FREXP: begin
        if (spec) val_d = s2_q.x;
        else if (s2_q.cls == frc_pkg::CLS_SUBNORMAL) begin
          val_d = sgn | frc_pkg::HALF_BITS
                  | ((s2_q.x << (s2_q.lz + 6'd1)) & frc_pkg::FRAC_FIELD);
          ex_d  = -12'sd1022 - {6'd0, s2_q.lz};
        end else begin
          val_d = sgn | frc_pkg::HALF_BITS | (s2_q.x & frc_pkg::FRAC_FIELD);
          ex_d  = {1'b0, s2_q.x[62:52]} - 12'd1022;
        end
      end
      default: val_d = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      val_q <= val_d;
      ex_q  <= ex_d;
      cls_q <= s2_q.cls;
    end
  end

  assign out_valid_o    = v3_q;
  assign value_out_o    = val_q;
  assign exponent_out_o = ex_q;
  assign fp_class_o     = cls_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && out_stall_i |=> v3_q && $stable(value_out_o))
    else $error("stalled beat changed");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (v3_q && out_stall_i))
    else $error("stall mismatch");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && v2_q |=> v3_q)
    else $error("beat lost");
endmodule
